FILE: sv/bfps_pkg.sv
// Shared types, constants and arithmetic helpers for the fern point step unit.
// Used by every module of the block; depends on nothing.
package bfps_pkg;

   localparam int THRESH_W  = 16;
   localparam int POS_W     = 18;
   localparam int FRAC_BITS = 12;
   localparam int COEF_W    = 13;
   localparam int PROD_W    = POS_W + COEF_W;
   localparam int ACC_W     = 32;
   localparam int Q_W       = ACC_W - FRAC_BITS;
   localparam int PIX_W     = 10;
   localparam int POS_MAX   = 131071;
   localparam int POS_MIN   = -131072;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 2;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes, taken from paddr[3:2].
   localparam logic [1:0] REG_THRESH_STEM       = 2'd0;
   localparam logic [1:0] REG_THRESH_LEFT_LEAF  = 2'd1;
   localparam logic [1:0] REG_THRESH_RIGHT_LEAF = 2'd2;

   localparam logic [THRESH_W-1:0] THRESH_STEM_RESET       = 16'd655;
   localparam logic [THRESH_W-1:0] THRESH_LEFT_LEAF_RESET  = 16'd3932;
   localparam logic [THRESH_W-1:0] THRESH_RIGHT_LEAF_RESET = 16'd9830;

   typedef enum logic [1:0] {
      MAP_STEM       = 2'd0,
      MAP_LEFT_LEAF  = 2'd1,
      MAP_RIGHT_LEAF = 2'd2,
      MAP_MAIN       = 2'd3
   } map_type;

   typedef struct packed {
      logic [THRESH_W-1:0] stem;
      logic [THRESH_W-1:0] left_leaf;
      logic [THRESH_W-1:0] right_leaf;
   } thresh_type;

   typedef struct packed {
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] x;
   } pos_type;

   function automatic map_type pick_map(input logic [THRESH_W-1:0] rnd,
                                        input thresh_type th);
      map_type m;
      if (rnd <= th.stem) begin
         m = MAP_STEM;
      end else if (rnd <= th.left_leaf) begin
         m = MAP_LEFT_LEAF;
      end else if (rnd <= th.right_leaf) begin
         m = MAP_RIGHT_LEAF;
      end else begin
         m = MAP_MAIN;
      end
      return m;
   endfunction

   // Map coefficients in Q.12.
   function automatic logic signed [COEF_W-1:0] coef_xx(input map_type m);
      logic signed [COEF_W-1:0] c;
      case (m)
         MAP_STEM:       c = 13'sd0;
         MAP_LEFT_LEAF:  c = -13'sd614;
         MAP_RIGHT_LEAF: c = 13'sd819;
         default:        c = 13'sd3482;
      endcase
      return c;
   endfunction

   function automatic logic signed [COEF_W-1:0] coef_xy(input map_type m);
      logic signed [COEF_W-1:0] c;
      case (m)
         MAP_STEM:       c = 13'sd0;
         MAP_LEFT_LEAF:  c = 13'sd1147;
         MAP_RIGHT_LEAF: c = -13'sd1065;
         default:        c = 13'sd164;
      endcase
      return c;
   endfunction

   function automatic logic signed [COEF_W-1:0] coef_yx(input map_type m);
      logic signed [COEF_W-1:0] c;
      case (m)
         MAP_STEM:       c = 13'sd0;
         MAP_LEFT_LEAF:  c = 13'sd1065;
         MAP_RIGHT_LEAF: c = 13'sd942;
         default:        c = -13'sd164;
      endcase
      return c;
   endfunction

   function automatic logic signed [COEF_W-1:0] coef_yy(input map_type m);
      logic signed [COEF_W-1:0] c;
      case (m)
         MAP_STEM:       c = 13'sd655;
         MAP_LEFT_LEAF:  c = 13'sd983;
         MAP_RIGHT_LEAF: c = 13'sd901;
         default:        c = 13'sd3482;
      endcase
      return c;
   endfunction

   // Offset of the y map already scaled to Q.24.
   function automatic logic signed [ACC_W-1:0] offset_y(input map_type m);
      logic signed [ACC_W-1:0] c;
      case (m)
         MAP_STEM:       c = 32'sd0;
         MAP_LEFT_LEAF:  c = 32'sd7380992;
         MAP_RIGHT_LEAF: c = 32'sd26845184;
         default:        c = 32'sd26845184;
      endcase
      return c;
   endfunction

   // Round a Q.24 sum to Q.12 (half up, floor) and saturate to the point width.
   function automatic logic signed [POS_W-1:0] round_sat(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      logic signed [Q_W-1:0]   q;
      logic signed [POS_W-1:0] s;
      r = v + ACC_W'(1 << (FRAC_BITS - 1));
      q = Q_W'(r >>> FRAC_BITS);
      if (q > Q_W'(POS_MAX)) begin
         s = POS_W'(POS_MAX);
      end else if (q < Q_W'(POS_MIN)) begin
         s = POS_W'(POS_MIN);
      end else begin
         s = q[POS_W-1:0];
      end
      return s;
   endfunction

endpackage

FILE: sv/bfps_csr.sv
// Threshold register file behind the APB-style configuration port.
// Depends on bfps_pkg for the register indexes, reset values and threshold struct.
module bfps_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bfps_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [bfps_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [bfps_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output bfps_pkg::thresh_type             thresh
);

   bfps_pkg::thresh_type thresh_ff;
   bfps_pkg::thresh_type thresh_in;
   logic [1:0]           reg_index;
   logic                 wr_en;

   assign reg_index  = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign thresh     = thresh_ff;

   always_comb begin
      thresh_in = thresh_ff;
      if (wr_en) begin
         unique case (reg_index)
            bfps_pkg::REG_THRESH_STEM:       thresh_in.stem       = csr_pwdata[15:0];
            bfps_pkg::REG_THRESH_LEFT_LEAF:  thresh_in.left_leaf  = csr_pwdata[15:0];
            bfps_pkg::REG_THRESH_RIGHT_LEAF: thresh_in.right_leaf = csr_pwdata[15:0];
            default:                         thresh_in = thresh_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         bfps_pkg::REG_THRESH_STEM:       csr_prdata = 32'(thresh_ff.stem);
         bfps_pkg::REG_THRESH_LEFT_LEAF:  csr_prdata = 32'(thresh_ff.left_leaf);
         bfps_pkg::REG_THRESH_RIGHT_LEAF: csr_prdata = 32'(thresh_ff.right_leaf);
         default:                         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff.stem       <= bfps_pkg::THRESH_STEM_RESET;
         thresh_ff.left_leaf  <= bfps_pkg::THRESH_LEFT_LEAF_RESET;
         thresh_ff.right_leaf <= bfps_pkg::THRESH_RIGHT_LEAF_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

endmodule

FILE: sv/bfps_affine.sv
// Affine map datapath: applies the selected map to the stored point and rounds.
// Depends on bfps_pkg for the coefficient tables and the round/saturate helper.
module bfps_affine (
   input  bfps_pkg::pos_type pos_old,
   input  logic              restart,
   input  bfps_pkg::map_type map_sel,
   output bfps_pkg::pos_type pos_new
);

   logic signed [bfps_pkg::POS_W-1:0]  ox;
   logic signed [bfps_pkg::POS_W-1:0]  oy;
   logic signed [bfps_pkg::PROD_W-1:0] p_xx;
   logic signed [bfps_pkg::PROD_W-1:0] p_xy;
   logic signed [bfps_pkg::PROD_W-1:0] p_yx;
   logic signed [bfps_pkg::PROD_W-1:0] p_yy;
   logic signed [bfps_pkg::ACC_W-1:0]  sum_x;
   logic signed [bfps_pkg::ACC_W-1:0]  sum_y;

   // A restart step runs the map from the origin.
   assign ox = restart ? '0 : pos_old.x;
   assign oy = restart ? '0 : pos_old.y;

   assign p_xx = bfps_pkg::PROD_W'(ox) * bfps_pkg::PROD_W'(bfps_pkg::coef_xx(map_sel));
   assign p_xy = bfps_pkg::PROD_W'(oy) * bfps_pkg::PROD_W'(bfps_pkg::coef_xy(map_sel));
   assign p_yx = bfps_pkg::PROD_W'(ox) * bfps_pkg::PROD_W'(bfps_pkg::coef_yx(map_sel));
   assign p_yy = bfps_pkg::PROD_W'(oy) * bfps_pkg::PROD_W'(bfps_pkg::coef_yy(map_sel));

   assign sum_x = bfps_pkg::ACC_W'(p_xx) + bfps_pkg::ACC_W'(p_xy);
   assign sum_y = bfps_pkg::ACC_W'(p_yx) + bfps_pkg::ACC_W'(p_yy)
                + bfps_pkg::offset_y(map_sel);

   assign pos_new.x = bfps_pkg::round_sat(sum_x);
   assign pos_new.y = bfps_pkg::round_sat(sum_y);

endmodule

FILE: sv/bfps_pixel.sv
// Screen mapping: scales a Q6.12 point to pixel column and row with clamping.
// Depends on bfps_pkg for the point type and widths.
module bfps_pixel #(
   parameter int SCREEN_BITS = 10
) (
   input  bfps_pkg::pos_type               pos,
   output logic [bfps_pkg::PIX_W-1:0]      pix_x,
   output logic [bfps_pkg::PIX_W-1:0]      pix_y
);

   localparam int NUM_W  = 26;
   localparam int QUOT_W = NUM_W - bfps_pkg::FRAC_BITS;
   localparam int PIX_SCALE = 70;
   // (x + 3) * 70 + 300 and 750 - y * 70, with the constant parts in Q.12.
   localparam int X_BIAS = (3 * PIX_SCALE + 300) << bfps_pkg::FRAC_BITS;
   localparam int Y_BIAS = 750 << bfps_pkg::FRAC_BITS;
   localparam logic [QUOT_W-1:0] PIX_TOP = QUOT_W'((1 << SCREEN_BITS) - 1);

   logic signed [NUM_W-1:0] num_x;
   logic signed [NUM_W-1:0] num_y;

   // Negative values truncate to zero or below, so they clamp to zero.
   function automatic logic [bfps_pkg::PIX_W-1:0] to_pix(input logic signed [NUM_W-1:0] num);
      logic [QUOT_W-1:0] q;
      if (num[NUM_W-1]) begin
         q = '0;
      end else if (num[NUM_W-1:bfps_pkg::FRAC_BITS] > PIX_TOP) begin
         q = PIX_TOP;
      end else begin
         q = num[NUM_W-1:bfps_pkg::FRAC_BITS];
      end
      return q[bfps_pkg::PIX_W-1:0];
   endfunction

   assign num_x = NUM_W'(pos.x) * NUM_W'(PIX_SCALE) + NUM_W'(X_BIAS);
   assign num_y = NUM_W'(Y_BIAS) - NUM_W'(pos.y) * NUM_W'(PIX_SCALE);

   assign pix_x = to_pix(num_x);
   assign pix_y = to_pix(num_y);

endmodule

FILE: sv/barnsley_fern_point_step_unit.sv
// Top level of the fern point step unit: three-stage pipeline around the
// threshold registers, the affine map datapath and the screen mapping.
// Depends on bfps_pkg, bfps_csr, bfps_affine and bfps_pixel.
//
// Usage:
//   req channel: one beat per chaos-game step. tdata[15:0] is the random value,
//   tdata[16] a restart flag that moves the point back to the origin first.
//   rsp channel: one beat per step. tdata[9:0] is the pixel column, tdata[19:10]
//   the pixel row, tuser[1:0] the map that was applied.
//   csr port: three 16-bit thresholds at byte addresses 0, 4 and 8; write them
//   only while no step is in flight.
// Flow: the map is chosen as the beat is registered in the first stage, the
// point register is updated as the step enters the second stage and the pixel
// of that point lands in the output register as the step leaves it.
// One beat per cycle is sustained while the receiver takes responses; the only
// loop is the point register feeding the affine map back to itself.
// Reset clears the point to the origin, the thresholds to their defaults and
// empties every stage. A stalled receiver holds the output beat; the stages
// behind it keep filling, and req_tready drops once all three hold a beat.
module barnsley_fern_point_step_unit #(
   parameter int SCREEN_BITS = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bfps_pkg::REQ_DATA_W-1:0]    req_tdata,   // rnd[15:0], restart[16], zero
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bfps_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // pix_x[9:0], pix_y[19:10], zero
   output logic [bfps_pkg::RSP_USER_W-1:0]    rsp_tuser,   // map_used[1:0]
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bfps_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [bfps_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bfps_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   bfps_pkg::thresh_type thresh;

   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   bfps_pkg::map_type    s1_map_ff;
   logic                 s1_restart_ff;

   logic                 s2_valid_ff;
   logic                 s2_valid_in;
   bfps_pkg::map_type    s2_map_ff;
   bfps_pkg::pos_type    pos_ff;
   bfps_pkg::pos_type    pos_in;

   logic                 out_valid_ff;
   logic                 out_valid_in;
   bfps_pkg::map_type    out_map_ff;
   logic [bfps_pkg::PIX_W-1:0] pix_x_ff;
   logic [bfps_pkg::PIX_W-1:0] pix_y_ff;
   logic [bfps_pkg::PIX_W-1:0] pix_x_in;
   logic [bfps_pkg::PIX_W-1:0] pix_y_in;

   logic                 req_accept;
   logic                 out_load;
   logic                 s2_load;

   bfps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .thresh      (thresh)
   );

   bfps_affine u_affine (
      .pos_old (pos_ff),
      .restart (s1_restart_ff),
      .map_sel (s1_map_ff),
      .pos_new (pos_in)
   );

   bfps_pixel #(
      .SCREEN_BITS (SCREEN_BITS)
   ) u_pixel (
      .pos   (pos_ff),
      .pix_x (pix_x_in),
      .pix_y (pix_y_in)
   );

   // Each stage loads when it is empty or its beat moves on in the same cycle.
   assign out_load   = s2_valid_ff && (!out_valid_ff || rsp_tready);
   assign s2_load    = s1_valid_ff && (!s2_valid_ff || out_load);
   assign req_tready = !s1_valid_ff || s2_load;
   assign req_accept = req_tvalid && req_tready;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s2_load);
   assign s2_valid_in  = s2_load || (s2_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_tready);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, pix_y_ff, pix_x_ff};
   assign rsp_tuser  = out_map_ff;

   // The point register doubles as the second stage's payload and as the state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
         if (s2_load) begin
            pos_ff <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_map_ff     <= bfps_pkg::pick_map(req_tdata[15:0], thresh);
         s1_restart_ff <= req_tdata[16];
      end
      if (s2_load) begin
         s2_map_ff <= s1_map_ff;
      end
      if (out_load) begin
         out_map_ff <= s2_map_ff;
         pix_x_ff   <= pix_x_in;
         pix_y_ff   <= pix_y_in;
      end
   end

   // The point only moves when a step enters the second stage.
   a_pos_holds: assert property (@(posedge clock) disable iff (reset)
      !s2_load |=> $stable(pos_ff))
      else $error("point register changed without a step");

   // The stem map always collapses x to zero.
   a_stem_zero_x: assert property (@(posedge clock) disable iff (reset)
      s2_load && (s1_map_ff == bfps_pkg::MAP_STEM) |=> pos_ff.x == '0)
      else $error("stem map left a nonzero x");

   // Input back-pressure only when every stage holds a beat.
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && s2_valid_ff && out_valid_ff && !rsp_tready)
      else $error("request stalled with room in the pipeline");

   // A stalled response keeps its beat.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

endmodule
